@@ design/slater_effective_charge_assert.svh @@
// Assertion macros for the checker file of the effective charge block.
`ifndef SLATER_EFFECTIVE_CHARGE_ASSERT_SVH
`define SLATER_EFFECTIVE_CHARGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
// The check is switched off while reset is held.
`define SEC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sec_pkg.sv @@
// Shared widths, orbital tables, register indexes and stage types of the effective charge block.
package sec_pkg;

    localparam int N_W         = 3;
    localparam int L_W         = 2;
    localparam int GROUP_W     = 4;
    localparam int OCC_W       = 4;
    localparam int WEIGHT_W    = 7;

    localparam int Z_W         = 7;
    localparam int S_OCC_W     = 14;
    localparam int P_OCC_W     = 18;
    localparam int D_OCC_W     = 16;
    localparam int F_OCC_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    localparam int NUM_ORB     = 19;
    localparam int NUM_PART    = 4;
    localparam int PART_LEN    = 5;
    localparam int CONTRIB_W   = 11;
    localparam int PSUM_W      = 13;
    localparam int SCREEN_W    = 15;
    localparam int ZEFF_W      = 14;
    localparam int SQ_W        = 2 * ZEFF_W;
    localparam int COEF_W      = 30;
    localparam int PROD_W      = SQ_W + COEF_W;
    localparam int FRAC_W      = 32;
    localparam int ENERGY_W    = 26;

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = ZEFF_W + ENERGY_W;

    // Angular codes.
    localparam logic [L_W-1:0] L_S = 2'd0;
    localparam logic [L_W-1:0] L_P = 2'd1;
    localparam logic [L_W-1:0] L_D = 2'd2;
    localparam logic [L_W-1:0] L_F = 2'd3;

    // Screening weights per electron, in hundredths.
    localparam logic [WEIGHT_W-1:0] W_SAME_1S = 7'd30;
    localparam logic [WEIGHT_W-1:0] W_SAME    = 7'd35;
    localparam logic [WEIGHT_W-1:0] W_NEXT    = 7'd85;
    localparam logic [WEIGHT_W-1:0] W_INNER   = 7'd100;

    localparam logic [ZEFF_W-1:0] ZEFF_MIN   = 14'd100;
    localparam logic [ZEFF_W-1:0] ZEFF_SCALE = 14'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ATOMIC_NUMBER = 3'd0,
        REG_S_OCCUPANCY   = 3'd1,
        REG_P_OCCUPANCY   = 3'd2,
        REG_D_OCCUPANCY   = 3'd3,
        REG_F_OCCUPANCY   = 3'd4
    } cfg_reg_t;

    // The held orbitals: 1s..7s, 2p..7p, 3d..6d, 4f, 5f in filling order.
    localparam logic [N_W-1:0] ORB_N [NUM_ORB] = '{
        3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd4,
        3'd5, 3'd6, 3'd4, 3'd5, 3'd6, 3'd7, 3'd5, 3'd6, 3'd7
    };
    localparam logic [L_W-1:0] ORB_L [NUM_ORB] = '{
        2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2,
        2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1
    };

    // Rydberg energy over (100 * nstar^2), as a fraction with 32 fraction bits.
    localparam logic [COEF_W-1:0] ENERGY_COEF [8] = '{
        30'd0,        30'd584364660, 30'd146091165, 30'd64929407,
        30'd42685512, 30'd36522791,  30'd33127248,  30'd33127248
    };

    // Screening group of an orbital; unlisted orbitals fall back to group 2n.
    function automatic logic [GROUP_W-1:0] group_of(input logic [N_W-1:0] n,
                                                     input logic [L_W-1:0] l);
        logic [GROUP_W-1:0] g;
        g = {n, 1'b0};
        if (l == L_D || l == L_F) begin
            case ({n, l})
                {3'd3, L_D}: g = 4'd3;
                {3'd4, L_D}: g = 4'd5;
                {3'd4, L_F}: g = 4'd6;
                {3'd5, L_D}: g = 4'd8;
                {3'd5, L_F}: g = 4'd9;
                {3'd6, L_D}: g = 4'd11;
                {3'd6, L_F}: g = 4'd12;
                default:     g = {n, 1'b0};
            endcase
        end else begin
            case (n)
                3'd1:    g = 4'd0;
                3'd2:    g = 4'd1;
                3'd3:    g = 4'd2;
                3'd4:    g = 4'd4;
                3'd5:    g = 4'd7;
                3'd6:    g = 4'd10;
                3'd7:    g = 4'd13;
                default: g = {n, 1'b0};
            endcase
        end
        return g;
    endfunction

    // Screening sums split into partial sums.
    typedef struct packed {
        logic                             valid;
        logic [N_W-1:0]                   n;
        logic [NUM_PART-1:0][PSUM_W-1:0]  psum;
    } scr_t;

    // Clamped effective charge.
    typedef struct packed {
        logic              valid;
        logic [N_W-1:0]    n;
        logic [ZEFF_W-1:0] zeff;
    } zeff_t;

    // Energy product before rounding.
    typedef struct packed {
        logic              valid;
        logic [ZEFF_W-1:0] zeff;
        logic [PROD_W-1:0] prod;
    } prod_t;

endpackage

@@ design/slater_effective_charge.sv @@
// Top level of the Slater effective nuclear charge and orbital energy pipeline.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  target orbital (n, l)
//  m_*       out        m_tvalid/m_tready  effective charge and orbital energy
//  cfg_*     in         cfg_we             charge and occupancy registers
//
// One beat enters per cycle while s_tready is high; the accepting edge loads the first of six
// stages: two screening, clamp, square, product, and output register.
// All stages share one advance enable, so a stall at the output freezes the whole pipe
// and no beat is lost or repeated; s_tready is high whenever the output register is
// empty or is being taken. A synchronous reset clears every valid bit and loads the
// configuration defaults (charge of one, all orbitals empty).
module slater_effective_charge (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // principal_number [2:0], angular_number [4:3], zero fill [7:5]
    input  logic [sec_pkg::S_TDATA_W-1:0]     s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // zeff_hundredths [13:0], energy_centi_ev [39:14]
    output logic [sec_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                              cfg_we,
    input  logic [sec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sec_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sec_pkg::*;

    localparam int RND_W = PROD_W + 1;

    // Configuration registers.
    logic [Z_W-1:0]     atomic_number_reg;
    logic [S_OCC_W-1:0] s_occ_reg;
    logic [P_OCC_W-1:0] p_occ_reg;
    logic [D_OCC_W-1:0] d_occ_reg;
    logic [F_OCC_W-1:0] f_occ_reg;

    // Pipeline control and stage outputs.
    logic  advance;
    scr_t  scr;
    zeff_t zq;
    prod_t pq;

    // Output stage.
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic [RND_W-1:0]    rounded;
    logic [ENERGY_W-1:0] magnitude;
    logic [ENERGY_W-1:0] energy;

    // The user must write the configuration only while the pipe is empty; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atomic_number_reg <= Z_W'(1);
            s_occ_reg         <= '0;
            p_occ_reg         <= '0;
            d_occ_reg         <= '0;
            f_occ_reg         <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ATOMIC_NUMBER: atomic_number_reg <= cfg_data[Z_W-1:0];
                REG_S_OCCUPANCY:   s_occ_reg         <= cfg_data[S_OCC_W-1:0];
                REG_P_OCCUPANCY:   p_occ_reg         <= cfg_data[P_OCC_W-1:0];
                REG_D_OCCUPANCY:   d_occ_reg         <= cfg_data[D_OCC_W-1:0];
                REG_F_OCCUPANCY:   f_occ_reg         <= cfg_data[F_OCC_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipe moves whenever the output register can take a new beat.
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    sec_screen u_screen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_valid (s_tvalid),
        .n        (s_tdata[N_W-1:0]),
        .l        (s_tdata[N_W +: L_W]),
        .s_occ    (s_occ_reg),
        .p_occ    (p_occ_reg),
        .d_occ    (d_occ_reg),
        .f_occ    (f_occ_reg),
        .scr      (scr)
    );

    sec_zeff u_zeff (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .atomic_number (atomic_number_reg),
        .scr           (scr),
        .zq            (zq)
    );

    sec_energy u_energy (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .zq      (zq),
        .pq      (pq)
    );

    // Round the 32-bit fraction to nearest and negate: orbital energies are bound.
    assign rounded   = RND_W'(pq.prod) + (RND_W'(1) << (FRAC_W - 1));
    assign magnitude = rounded[FRAC_W +: ENERGY_W];
    assign energy    = ENERGY_W'(0) - magnitude;

    assign m_valid_next = pq.valid;
    assign m_data_next  = {energy, pq.zeff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ design/sec_screen.sv @@
// Screening stages: per-orbital weighted counts, then registered partial sums.
module sec_screen (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [sec_pkg::N_W-1:0]       n,
    input  logic [sec_pkg::L_W-1:0]       l,
    input  logic [sec_pkg::S_OCC_W-1:0]   s_occ,
    input  logic [sec_pkg::P_OCC_W-1:0]   p_occ,
    input  logic [sec_pkg::D_OCC_W-1:0]   d_occ,
    input  logic [sec_pkg::F_OCC_W-1:0]   f_occ,
    output sec_pkg::scr_t                 scr
);
    import sec_pkg::*;

    logic [GROUP_W-1:0]   tgt_group;
    logic [CONTRIB_W-1:0] contrib_next [NUM_ORB];
    logic [CONTRIB_W-1:0] contrib_reg  [NUM_ORB];
    logic                 v1_reg;
    logic [N_W-1:0]       n1_reg;

    logic [NUM_PART-1:0][PSUM_W-1:0] psum_next;
    logic [NUM_PART-1:0][PSUM_W-1:0] psum_reg;
    logic                            v2_reg;
    logic [N_W-1:0]                  n2_reg;

    assign tgt_group = group_of(n, l);

    for (genvar i = 0; i < NUM_ORB; i++) begin : g_orb
        localparam int                 ON = int'(ORB_N[i]);
        localparam logic [GROUP_W-1:0] OG = group_of(ORB_N[i], ORB_L[i]);

        logic [OCC_W-1:0]    occ;
        logic [OCC_W-1:0]    cnt;
        logic [WEIGHT_W-1:0] weight;
        logic                hit;

        if (ORB_L[i] == L_S) begin : g_s
            assign occ = {2'b00, s_occ[2*(ON-1) +: 2]};
        end else if (ORB_L[i] == L_P) begin : g_p
            assign occ = {1'b0, p_occ[3*(ON-2) +: 3]};
        end else if (ORB_L[i] == L_D) begin : g_d
            assign occ = d_occ[4*(ON-3) +: 4];
        end else begin : g_f
            assign occ = f_occ[4*(ON-4) +: 4];
        end

        // The target's own electron does not screen itself.
        assign hit = (n == ORB_N[i]) && (l == ORB_L[i]);
        assign cnt = hit ? ((occ == '0) ? '0 : occ - 4'd1) : occ;

        always_comb begin
            weight = '0;
            if (l == L_S || l == L_P) begin
                if (OG == tgt_group) begin
                    weight = (n == 3'd1) ? W_SAME_1S : W_SAME;
                end else if ({1'b0, OG} + 5'd1 == {1'b0, tgt_group}) begin
                    weight = W_NEXT;
                end else if ({1'b0, OG} + 5'd1 < {1'b0, tgt_group}) begin
                    weight = W_INNER;
                end
            end else begin
                if (OG == tgt_group) begin
                    weight = W_SAME;
                end else if (OG < tgt_group) begin
                    weight = W_INNER;
                end
            end
        end

        assign contrib_next[i] = CONTRIB_W'(cnt) * CONTRIB_W'(weight);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            contrib_reg <= contrib_next;
            n1_reg      <= n;
            psum_reg    <= psum_next;
            n2_reg      <= n1_reg;
        end
    end

    always_comb begin
        int idx;
        for (int p = 0; p < NUM_PART; p++) begin
            psum_next[p] = '0;
            for (int k = 0; k < PART_LEN; k++) begin
                idx = p * PART_LEN + k;
                if (idx < NUM_ORB) begin
                    psum_next[p] = psum_next[p] + PSUM_W'(contrib_reg[idx]);
                end
            end
        end
    end

    assign scr.valid = v2_reg;
    assign scr.n     = n2_reg;
    assign scr.psum  = psum_reg;

endmodule

@@ design/sec_zeff.sv @@
// Final screening sum and clamped effective charge stage.
module sec_zeff (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic [sec_pkg::Z_W-1:0] atomic_number,
    input  sec_pkg::scr_t           scr,
    output sec_pkg::zeff_t          zq
);
    import sec_pkg::*;

    localparam int CALC_W = SCREEN_W + 1;

    logic [SCREEN_W-1:0] screen;
    logic [CALC_W-1:0]   charge;
    logic [ZEFF_W-1:0]   zeff_next;
    logic [ZEFF_W-1:0]   zeff_reg;
    logic [N_W-1:0]      n_reg;
    logic                v_reg;

    always_comb begin
        screen = '0;
        for (int p = 0; p < NUM_PART; p++) begin
            screen = screen + SCREEN_W'(scr.psum[p]);
        end
    end

    assign charge = CALC_W'(ZEFF_W'(atomic_number) * ZEFF_SCALE);

    // The charge never drops below one whole unit.
    always_comb begin
        if (CALC_W'(screen) + CALC_W'(ZEFF_MIN) > charge) begin
            zeff_next = ZEFF_MIN;
        end else begin
            zeff_next = ZEFF_W'(charge - CALC_W'(screen));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= scr.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zeff_reg <= zeff_next;
            n_reg    <= scr.n;
        end
    end

    assign zq.valid = v_reg;
    assign zq.n     = n_reg;
    assign zq.zeff  = zeff_reg;

endmodule

@@ design/sec_energy.sv @@
// Energy stages: square of the charge, then product with the level coefficient.
module sec_energy (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  sec_pkg::zeff_t  zq,
    output sec_pkg::prod_t  pq
);
    import sec_pkg::*;

    logic              v4_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [ZEFF_W-1:0] zeff4_reg;
    logic [N_W-1:0]    n4_reg;

    logic              v5_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ZEFF_W-1:0] zeff5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= zq.valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg    <= SQ_W'(zq.zeff) * SQ_W'(zq.zeff);
            zeff4_reg <= zq.zeff;
            n4_reg    <= zq.n;
            prod_reg  <= PROD_W'(sq_reg) * PROD_W'(ENERGY_COEF[n4_reg]);
            zeff5_reg <= zeff4_reg;
        end
    end

    assign pq.valid = v5_reg;
    assign pq.zeff  = zeff5_reg;
    assign pq.prod  = prod_reg;

endmodule

@@ design/slater_effective_charge_checker.sv @@
// Port-level checker for the effective charge block, bound to its top level.
`include "slater_effective_charge_assert.svh"

module slater_effective_charge_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `SEC_ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `SEC_ASSERT_NEXT(a_out_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result beat changed while stalled")
    `SEC_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input not ready with an empty output")
    `SEC_ASSERT_NOW(a_zeff_range, aclk, aresetn, m_tvalid, (m_tdata[13:0] >= 14'd100) && (m_tdata[13:0] <= 14'd12700), "effective charge out of range")
    `SEC_ASSERT_NOW(a_energy_sign, aclk, aresetn, m_tvalid, m_tdata[39] || (m_tdata[39:14] == 26'd0), "orbital energy is positive")

endmodule

bind slater_effective_charge slater_effective_charge_checker u_checker (.*);
